[src/spa_pkg.sv]
// ============================================================================
// spa_pkg - shared types and constants for the sparse polynomial adder
// Term layout, request structs, op codes, sequencer states and the
// internal table and compare interfaces.
// ============================================================================
package spa_pkg;

    localparam int TERMS_PER_POLY = 16;
    localparam int ADDR_W         = $clog2(TERMS_PER_POLY);
    localparam int CNT_W          = $clog2(TERMS_PER_POLY + 1);
    localparam int COEFF_W        = 16;
    localparam int EXPO_W         = 8;
    localparam int SUM_W          = COEFF_W + 1;
    localparam int OP_W           = 2;

    localparam logic [OP_W-1:0] OP_INS_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD        = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [COEFF_W-1:0] coeff;
        logic [EXPO_W-1:0]         expo;
    } in_req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_coeff;
        logic [EXPO_W-1:0]       sum_expo;
        logic                    last_term;
        logic                    overflow;
    } out_req_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic [EXPO_W-1:0]         expo;
    } term_t;

    localparam int TERM_W = $bits(term_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        term_t             wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_HEAD,
        ST_MERGE
    } state_t;

endpackage

[src/sparse_polynomial_adder.sv]
// ============================================================================
// sparse_polynomial_adder - sorted merge adder for two sparse polynomials
// Insert requests build two descending-exponent term tables; an add request
// merges them into a stream of result terms.
// ============================================================================
// An insert request that finds its table empty or full is done in its
// accept cycle; otherwise the scan walks it from the tail, one entry per
// cycle on the one comparator, moving each term with a smaller exponent up
// a slot, and writes the new term after the first with an equal or greater
// exponent, or at the head. An add request spends its accept cycle priming
// the RAM reads and then sends one result term per cycle (up to
// 2 * TERMS_PER_POLY), holding while the output is stalled; the block takes
// no request until the last term is in the output register. Results sit in
// an output register, so the next request is taken while one waits. Tables
// need no clearing pass after reset: the fill counts mark valid entries.
module sparse_polynomial_adder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  spa_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output spa_pkg::out_req_t out_data
);

    spa_pkg::ram_req_t                ram_a, ram_b;
    logic [spa_pkg::TERM_W-1:0]       rd_a_raw, rd_b_raw;
    spa_pkg::term_t                   rd_a, rd_b;
    logic [spa_pkg::EXPO_W-1:0]       cmp_x, cmp_y;
    spa_pkg::cmp_res_t                cmp;
    logic                             busy;
    logic                             out_ready;
    logic                             out_load;
    spa_pkg::out_req_t                out_ld_data;
    logic                             out_valid_reg, out_valid_next;
    spa_pkg::out_req_t                out_data_reg;

    assign rd_a = rd_a_raw;
    assign rd_b = rd_b_raw;

    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::TERMS_PER_POLY)
    ) u_ram_a (
        .clk   (clk),
        .we    (ram_a.we),
        .waddr (ram_a.waddr),
        .wdata (ram_a.wdata),
        .raddr (ram_a.raddr),
        .rdata (rd_a_raw)
    );

    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::TERMS_PER_POLY)
    ) u_ram_b (
        .clk   (clk),
        .we    (ram_b.we),
        .waddr (ram_b.waddr),
        .wdata (ram_b.wdata),
        .raddr (ram_b.raddr),
        .rdata (rd_b_raw)
    );

    spa_cmp u_cmp (
        .x   (cmp_x),
        .y   (cmp_y),
        .res (cmp)
    );

    spa_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .busy      (busy),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .ram_a     (ram_a),
        .ram_b     (ram_b),
        .cmp_x     (cmp_x),
        .cmp_y     (cmp_y),
        .cmp       (cmp),
        .out_ready (out_ready),
        .out_load  (out_load),
        .out_data  (out_ld_data)
    );

    assign in_stall  = busy;
    assign out_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_ld_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- assertions ----------------
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_ready)
        else $error("result loaded over an unaccepted result");

    a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> in_stall)
        else $error("result produced outside a merge");

    a_last_ends_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_ld_data.last_term) |=> !out_load)
        else $error("result produced after the last term");

    a_one_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_a.we && ram_b.we))
        else $error("both tables written in one cycle");

endmodule

[src/spa_ram.sv]
// ============================================================================
// spa_ram - generic single write port RAM
// One write and one read address per cycle, read data registered.
// ============================================================================
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/spa_cmp.sv]
// ============================================================================
// spa_cmp - shared exponent comparator
// Used for the insert position scan and for picking the merge head.
// ============================================================================
module spa_cmp (
    input  logic [spa_pkg::EXPO_W-1:0] x,
    input  logic [spa_pkg::EXPO_W-1:0] y,
    output spa_pkg::cmp_res_t          res
);

    always_comb
    begin
        res.gt = (x > y);
        res.eq = (x == y);
    end

endmodule

[src/spa_seq.sv]
// ============================================================================
// spa_seq - insert and merge sequencer
// Runs the sorted insert (one entry shifted per cycle) and the merge
// (one result term per cycle unless stalled) over the two term tables.
// ============================================================================
module spa_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  spa_pkg::in_req_t            in_data,
    output logic                        busy,
    input  spa_pkg::term_t              rd_a,
    input  spa_pkg::term_t              rd_b,
    output spa_pkg::ram_req_t           ram_a,
    output spa_pkg::ram_req_t           ram_b,
    output logic [spa_pkg::EXPO_W-1:0]  cmp_x,
    output logic [spa_pkg::EXPO_W-1:0]  cmp_y,
    input  spa_pkg::cmp_res_t           cmp,
    input  logic                        out_ready,
    output logic                        out_load,
    output spa_pkg::out_req_t           out_data
);

    spa_pkg::state_t                   state_reg, state_next;
    logic [spa_pkg::CNT_W-1:0]         cnt_a_reg, cnt_a_next;
    logic [spa_pkg::CNT_W-1:0]         cnt_b_reg, cnt_b_next;
    logic                              flag_reg, flag_next;
    logic                              sel_reg, sel_next;
    logic [spa_pkg::ADDR_W-1:0]        idx_reg, idx_next;
    spa_pkg::term_t                    new_reg, new_next;
    logic [spa_pkg::CNT_W-1:0]         ia_reg, ia_next;
    logic [spa_pkg::CNT_W-1:0]         ib_reg, ib_next;

    logic                              accept;
    logic                              in_sel;
    logic [spa_pkg::CNT_W-1:0]         cnt_sel;
    logic [spa_pkg::CNT_W-1:0]         cnt_dec;
    logic                              tbl_full;
    logic                              tbl_empty;
    logic                              both_empty;
    spa_pkg::term_t                    in_term;
    spa_pkg::term_t                    rd_sel;
    logic                              ins_stop;

    logic                              a_ok, b_ok;
    logic                              take_both, take_a;
    logic [spa_pkg::CNT_W-1:0]         ia_adv, ib_adv;
    logic                              merge_done;

    logic                              wr_en;
    logic                              wr_sel;
    logic [spa_pkg::ADDR_W-1:0]        wr_addr;
    spa_pkg::term_t                    wr_data;
    logic [spa_pkg::ADDR_W-1:0]        rd_addr_a, rd_addr_b;

    // ---------------- decode ----------------
    assign accept     = in_valid && (state_reg == spa_pkg::ST_IDLE);
    assign in_sel     = (in_data.op == spa_pkg::OP_INS_SECOND);
    assign cnt_sel    = in_sel ? cnt_b_reg : cnt_a_reg;
    assign cnt_dec    = cnt_sel - spa_pkg::CNT_W'(1);
    assign tbl_full   = (cnt_sel == spa_pkg::CNT_W'(spa_pkg::TERMS_PER_POLY));
    assign tbl_empty  = (cnt_sel == '0);
    assign both_empty = (cnt_a_reg == '0) && (cnt_b_reg == '0);
    assign in_term    = '{coeff: in_data.coeff, expo: in_data.expo};
    assign rd_sel     = sel_reg ? rd_b : rd_a;
    assign busy       = (state_reg != spa_pkg::ST_IDLE);

    // comparator operands: insert scans against the new term, merge compares heads
    always_comb
    begin
        if (state_reg == spa_pkg::ST_MERGE)
        begin
            cmp_x = rd_a.expo;
            cmp_y = rd_b.expo;
        end
        else
        begin
            cmp_x = rd_sel.expo;
            cmp_y = new_reg.expo;
        end
    end

    // stored term has equal or greater exponent: new term goes right after it
    assign ins_stop = cmp.gt || cmp.eq;

    // ---------------- merge head selection ----------------
    always_comb
    begin
        a_ok       = (ia_reg < cnt_a_reg);
        b_ok       = (ib_reg < cnt_b_reg);
        take_both  = a_ok && b_ok && cmp.eq;
        take_a     = !take_both && (!b_ok || (a_ok && cmp.gt));
        ia_adv     = (take_both || take_a) ? ia_reg + spa_pkg::CNT_W'(1) : ia_reg;
        ib_adv     = (take_both || !take_a) ? ib_reg + spa_pkg::CNT_W'(1) : ib_reg;
        merge_done = (ia_adv >= cnt_a_reg) && (ib_adv >= cnt_b_reg);
    end

    always_comb
    begin
        out_data.sum_expo  = take_a ? rd_a.expo : rd_b.expo;
        out_data.last_term = merge_done;
        out_data.overflow  = flag_reg;
        if (take_both)
        begin
            out_data.sum_coeff = {rd_a.coeff[spa_pkg::COEFF_W-1], rd_a.coeff}
                               + {rd_b.coeff[spa_pkg::COEFF_W-1], rd_b.coeff};
        end
        else if (take_a)
        begin
            out_data.sum_coeff = {rd_a.coeff[spa_pkg::COEFF_W-1], rd_a.coeff};
        end
        else
        begin
            out_data.sum_coeff = {rd_b.coeff[spa_pkg::COEFF_W-1], rd_b.coeff};
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.op) inside
                        spa_pkg::OP_INS_FIRST, spa_pkg::OP_INS_SECOND:
                        begin
                            if (!tbl_full && !tbl_empty)
                            begin
                                state_next = spa_pkg::ST_INS_SCAN;
                            end
                        end
                        spa_pkg::OP_ADD:
                        begin
                            if (!both_empty)
                            begin
                                state_next = spa_pkg::ST_MERGE;
                            end
                        end
                        default:
                        begin
                            state_next = spa_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            spa_pkg::ST_INS_SCAN:
            begin
                if (ins_stop)
                begin
                    state_next = spa_pkg::ST_IDLE;
                end
                else if (idx_reg == spa_pkg::ADDR_W'(1))
                begin
                    state_next = spa_pkg::ST_INS_HEAD;
                end
            end
            spa_pkg::ST_INS_HEAD:
            begin
                state_next = spa_pkg::ST_IDLE;
            end
            spa_pkg::ST_MERGE:
            begin
                if (out_ready && merge_done)
                begin
                    state_next = spa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spa_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and table control ----------------
    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        flag_next  = flag_reg;
        sel_next   = sel_reg;
        idx_next   = idx_reg;
        new_next   = new_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        wr_en      = 1'b0;
        wr_sel     = sel_reg;
        wr_addr    = idx_reg;
        wr_data    = new_reg;
        rd_addr_a  = idx_reg - spa_pkg::ADDR_W'(2);
        rd_addr_b  = idx_reg - spa_pkg::ADDR_W'(2);
        out_load   = 1'b0;

        unique case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                rd_addr_a = cnt_dec[spa_pkg::ADDR_W-1:0];
                rd_addr_b = cnt_dec[spa_pkg::ADDR_W-1:0];
                if (accept)
                begin
                    unique case (in_data.op) inside
                        spa_pkg::OP_INS_FIRST, spa_pkg::OP_INS_SECOND:
                        begin
                            sel_next = in_sel;
                            new_next = in_term;
                            idx_next = cnt_sel[spa_pkg::ADDR_W-1:0];
                            if (tbl_full)
                            begin
                                flag_next = 1'b1;
                            end
                            else
                            begin
                                if (in_sel)
                                begin
                                    cnt_b_next = cnt_b_reg + spa_pkg::CNT_W'(1);
                                end
                                else
                                begin
                                    cnt_a_next = cnt_a_reg + spa_pkg::CNT_W'(1);
                                end
                                // empty table: write straight to the head
                                if (tbl_empty)
                                begin
                                    wr_en   = 1'b1;
                                    wr_sel  = in_sel;
                                    wr_addr = '0;
                                    wr_data = in_term;
                                end
                            end
                        end
                        spa_pkg::OP_ADD:
                        begin
                            ia_next   = '0;
                            ib_next   = '0;
                            rd_addr_a = '0;
                            rd_addr_b = '0;
                            if (both_empty)
                            begin
                                flag_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            ia_next = ia_reg;
                        end
                    endcase
                end
            end
            spa_pkg::ST_INS_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (ins_stop)
                begin
                    wr_data = new_reg;
                end
                else
                begin
                    // shift the smaller term up one slot
                    wr_data  = rd_sel;
                    idx_next = idx_reg - spa_pkg::ADDR_W'(1);
                end
            end
            spa_pkg::ST_INS_HEAD:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = new_reg;
            end
            spa_pkg::ST_MERGE:
            begin
                if (out_ready)
                begin
                    out_load = 1'b1;
                    ia_next  = ia_adv;
                    ib_next  = ib_adv;
                    if (merge_done)
                    begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        flag_next  = 1'b0;
                    end
                end
                // address follows the head so a stall simply rereads it
                rd_addr_a = ia_next[spa_pkg::ADDR_W-1:0];
                rd_addr_b = ib_next[spa_pkg::ADDR_W-1:0];
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_a.we    = wr_en && !wr_sel;
        ram_a.waddr = wr_addr;
        ram_a.wdata = wr_data;
        ram_a.raddr = rd_addr_a;
        ram_b.we    = wr_en && wr_sel;
        ram_b.waddr = wr_addr;
        ram_b.wdata = wr_data;
        ram_b.raddr = rd_addr_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spa_pkg::ST_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            flag_reg  <= 1'b0;
            sel_reg   <= 1'b0;
            idx_reg   <= '0;
            ia_reg    <= '0;
            ib_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            flag_reg  <= flag_next;
            sel_reg   <= sel_next;
            idx_reg   <= idx_next;
            ia_reg    <= ia_next;
            ib_reg    <= ib_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
    end

endmodule

[verif/tb_sparse_polynomial_adder.sv]
// ============================================================================
// tb_sparse_polynomial_adder - self-checking bench for the sparse poly adder
// Loads term tables through the request channel and checks every merged
// result term against a local sorted-table predictor. Opens with a short
// table of corner requests, then runs random load/add sequences (some
// overflowing a table) under three sender/receiver idle mixes.
// ============================================================================
module tb_sparse_polynomial_adder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [spa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 440;
    // worst quiet stretch: the longest insert plus long random stall/idle runs
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 48;

    typedef struct packed {
        spa_pkg::in_req_t  req;
        logic              typed;
        spa_pkg::out_req_t want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    spa_pkg::in_req_t  in_data;
    logic              out_valid;
    logic              out_stall;
    spa_pkg::out_req_t out_data;

    // predictor state: index 0 is the first polynomial, 1 the second
    spa_pkg::term_t    poly_tab [2][spa_pkg::TERMS_PER_POLY];
    int                poly_cnt [2];
    logic              dropped;

    spa_pkg::out_req_t merged_terms[$];
    spa_pkg::out_req_t expected_terms[$];
    dir_row_t          pending_rows[$];
    dir_row_t          dir_tab[$];

    int unsigned idle_pct;
    int unsigned stall_pct;
    int errors;
    int items_sent;
    int terms_checked;
    int adds_seen;
    int overflow_adds;
    int quiet_cycles;

    sparse_polynomial_adder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void store_term(int sel, spa_pkg::term_t t);
        int pos;
        pos = 0;
        if (poly_cnt[sel] >= spa_pkg::TERMS_PER_POLY)
        begin
            dropped = 1'b1;
            return;
        end
        // new term lands after every stored term with equal or larger exponent
        while (pos < poly_cnt[sel] && poly_tab[sel][pos].expo >= t.expo)
            pos++;
        for (int i = poly_cnt[sel]; i > pos; i--)
            poly_tab[sel][i] = poly_tab[sel][i-1];
        poly_tab[sel][pos] = t;
        poly_cnt[sel]++;
    endfunction

    function automatic void merge_tables();
        int a;
        int b;
        spa_pkg::out_req_t t;
        logic signed [spa_pkg::SUM_W-1:0] ca;
        logic signed [spa_pkg::SUM_W-1:0] cb;
        a = 0;
        b = 0;
        merged_terms.delete();
        while (a < poly_cnt[0] || b < poly_cnt[1])
        begin
            t = '0;
            t.overflow = dropped;
            if (a < poly_cnt[0] && b < poly_cnt[1] &&
                poly_tab[0][a].expo == poly_tab[1][b].expo)
            begin
                ca = $signed(poly_tab[0][a].coeff);
                cb = $signed(poly_tab[1][b].coeff);
                t.sum_coeff = ca + cb;
                t.sum_expo  = poly_tab[0][a].expo;
                a++;
                b++;
            end
            else if (b >= poly_cnt[1] ||
                     (a < poly_cnt[0] &&
                      poly_tab[0][a].expo > poly_tab[1][b].expo))
            begin
                t.sum_coeff = $signed(poly_tab[0][a].coeff);
                t.sum_expo  = poly_tab[0][a].expo;
                a++;
            end
            else
            begin
                t.sum_coeff = $signed(poly_tab[1][b].coeff);
                t.sum_expo  = poly_tab[1][b].expo;
                b++;
            end
            merged_terms.push_back(t);
        end
        if (merged_terms.size() > 0)
            merged_terms[merged_terms.size()-1].last_term = 1'b1;
        poly_cnt[0] = 0;
        poly_cnt[1] = 0;
        dropped = 1'b0;
    endfunction

    function automatic void predict_request(spa_pkg::in_req_t r, dir_row_t row);
        spa_pkg::term_t t;
        t.coeff = r.coeff;
        t.expo  = r.expo;
        case (r.op)
            spa_pkg::OP_INS_FIRST:  store_term(0, t);
            spa_pkg::OP_INS_SECOND: store_term(1, t);
            spa_pkg::OP_ADD:
            begin
                adds_seen++;
                if (dropped)
                    overflow_adds++;
                merge_tables();
                if (row.typed)
                    expected_terms.push_back(row.want);
                else
                    foreach (merged_terms[i])
                        expected_terms.push_back(merged_terms[i]);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_term(spa_pkg::out_req_t got);
        spa_pkg::out_req_t want;
        terms_checked++;
        if (expected_terms.size() == 0)
        begin
            $error("result term with nothing expected: coeff %0d expo %0d",
                   got.sum_coeff, got.sum_expo);
            errors++;
            return;
        end
        want = expected_terms.pop_front();
        if (got.sum_coeff !== want.sum_coeff)
        begin
            $error("sum_coeff: expected %0d, got %0d", want.sum_coeff, got.sum_coeff);
            errors++;
        end
        if (got.sum_expo !== want.sum_expo)
        begin
            $error("sum_expo: expected %0d, got %0d", want.sum_expo, got.sum_expo);
            errors++;
        end
        if (got.last_term !== want.last_term)
        begin
            $error("last_term: expected %0b, got %0b", want.last_term, got.last_term);
            errors++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor, scoreboard and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_request(in_data, pending_rows.pop_front());
            if (out_valid && !out_stall)
                check_term(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic dir_row_t plain(logic [spa_pkg::OP_W-1:0] op, int c, int e);
        dir_row_t row;
        row = '0;
        row.req.op    = op;
        row.req.coeff = c[spa_pkg::COEFF_W-1:0];
        row.req.expo  = e[spa_pkg::EXPO_W-1:0];
        return row;
    endfunction

    // add request whose merge gives exactly one term, no overflow
    function automatic dir_row_t add_one(int c, int e);
        dir_row_t row;
        row = plain(spa_pkg::OP_ADD, 0, 0);
        row.typed           = 1'b1;
        row.want.sum_coeff  = c[spa_pkg::SUM_W-1:0];
        row.want.sum_expo   = e[spa_pkg::EXPO_W-1:0];
        row.want.last_term  = 1'b1;
        return row;
    endfunction

    // caller sits at a falling edge; returns at the falling edge after accept
    task automatic send_row(dir_row_t row);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pending_rows.push_back(row);
        in_valid <= 1'b1;
        in_data  <= row.req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (row.req.op != OP_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [spa_pkg::COEFF_W-1:0] pick_coeff();
        case ($urandom_range(11))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return spa_pkg::COEFF_W'($urandom);
        endcase
    endfunction

    task automatic run_sequence();
        int n [2];
        int sel;
        int base;
        logic narrow;
        dir_row_t row;
        case ($urandom_range(99) / 12)
            0:
            begin
                // fill one table to capacity or past it
                n[0] = $urandom_range(spa_pkg::TERMS_PER_POLY,
                                      spa_pkg::TERMS_PER_POLY + 3);
                n[1] = $urandom_range(0, spa_pkg::TERMS_PER_POLY + 1);
            end
            1:
            begin
                n[0] = $urandom_range(0, 6);
                n[1] = ($urandom_range(1)) ? 0
                     : $urandom_range(spa_pkg::TERMS_PER_POLY - 1,
                                      spa_pkg::TERMS_PER_POLY + 2);
            end
            default:
            begin
                n[0] = $urandom_range(0, 8);
                n[1] = $urandom_range(0, 8);
            end
        endcase
        narrow = $urandom_range(1);
        base   = $urandom_range(0, 248);
        while (n[0] + n[1] > 0)
        begin
            if ($urandom_range(99) < 4)
                send_row(plain(OP_UNUSED, $urandom, $urandom));
            else if ($urandom_range(99) < 3)
                send_row(plain(spa_pkg::OP_ADD, $urandom, $urandom));
            sel = ($urandom_range(n[0] + n[1] - 1) < n[0]) ? 0 : 1;
            n[sel]--;
            row = plain(sel ? spa_pkg::OP_INS_SECOND : spa_pkg::OP_INS_FIRST, 0, 0);
            row.req.coeff = pick_coeff();
            row.req.expo  = narrow ? spa_pkg::EXPO_W'(base + $urandom_range(7))
                                   : spa_pkg::EXPO_W'($urandom);
            send_row(row);
        end
        send_row(plain(spa_pkg::OP_ADD, $urandom, $urandom));
    endtask

    initial
    begin
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        rst_n         = 1'b0;
        idle_pct      = 19;
        stall_pct     = 64;
        errors        = 0;
        items_sent    = 0;
        terms_checked = 0;
        adds_seen     = 0;
        overflow_adds = 0;
        quiet_cycles  = 0;
        poly_cnt[0]   = 0;
        poly_cnt[1]   = 0;
        dropped       = 1'b0;

        // extremes, one-sided adds, zero sum, empty add, unused op, duplicates
        dir_tab.push_back(plain(spa_pkg::OP_INS_FIRST, 32767, 255));
        dir_tab.push_back(plain(spa_pkg::OP_INS_SECOND, 32767, 255));
        dir_tab.push_back(add_one(65534, 255));
        dir_tab.push_back(plain(spa_pkg::OP_INS_FIRST, -32768, 0));
        dir_tab.push_back(plain(spa_pkg::OP_INS_SECOND, -32768, 0));
        dir_tab.push_back(add_one(-65536, 0));
        dir_tab.push_back(plain(spa_pkg::OP_ADD, 0, 0));
        dir_tab.push_back(plain(OP_UNUSED, -1, 255));
        dir_tab.push_back(plain(spa_pkg::OP_INS_FIRST, 1234, 77));
        dir_tab.push_back(add_one(1234, 77));
        dir_tab.push_back(plain(spa_pkg::OP_INS_SECOND, -5, 200));
        dir_tab.push_back(add_one(-5, 200));
        dir_tab.push_back(plain(spa_pkg::OP_INS_FIRST, 100, 7));
        dir_tab.push_back(plain(spa_pkg::OP_INS_SECOND, -100, 7));
        dir_tab.push_back(add_one(0, 7));
        dir_tab.push_back(plain(spa_pkg::OP_INS_FIRST, 5, 3));
        dir_tab.push_back(plain(spa_pkg::OP_INS_FIRST, 6, 3));
        dir_tab.push_back(plain(spa_pkg::OP_INS_FIRST, 9, 10));
        dir_tab.push_back(plain(spa_pkg::OP_INS_SECOND, 1, 3));
        dir_tab.push_back(plain(spa_pkg::OP_INS_SECOND, -2, 12));
        dir_tab.push_back(plain(spa_pkg::OP_INS_FIRST, -7, 0));
        dir_tab.push_back(plain(OP_UNUSED, 1, 3));
        dir_tab.push_back(plain(spa_pkg::OP_ADD, 0, 0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
            send_row(dir_tab[i]);

        while (items_sent < dir_tab.size() + RANDOM_ITEMS)
        begin
            case ((items_sent * 3) / (dir_tab.size() + RANDOM_ITEMS))
                0:
                begin
                    idle_pct  = 19;
                    stall_pct = 64;
                end
                1:
                begin
                    idle_pct  = 64;
                    stall_pct = 19;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            run_sequence();
        end
        in_valid <= 1'b0;

        while (expected_terms.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_terms.size() != 0)
        begin
            $error("%0d result terms never arrived", expected_terms.size());
            errors++;
        end
        $display("%0d requests sent, %0d add requests (%0d with a dropped insert),",
                 items_sent, adds_seen, overflow_adds);
        $display("%0d result terms checked, %0d mismatches", terms_checked, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
src/spa_pkg.sv
src/spa_ram.sv
src/spa_cmp.sv
src/spa_seq.sv
src/sparse_polynomial_adder.sv
verif/tb_sparse_polynomial_adder.sv
